FILE: design/ukph_pkg.sv
// Shared types and constants for the serial keyboard probe sequencer.
// Used by the front, queue, back and top-level modules; no dependencies.
package ukph_pkg;

  // Link phase codes
  localparam logic [2:0] PH_INIT      = 3'd0;
  localparam logic [2:0] PH_RTS_LOW   = 3'd1;
  localparam logic [2:0] PH_RTS_HIGH  = 3'd2;
  localparam logic [2:0] PH_ACK0      = 3'd3;
  localparam logic [2:0] PH_ACK1      = 3'd4;
  localparam logic [2:0] PH_CONNECTED = 3'd5;
  localparam logic [2:0] PH_GAVE_UP   = 3'd6;

  // Acknowledge bytes from the keyboard
  localparam logic [7:0] ACK_FIRST  = 8'hFA;
  localparam logic [7:0] ACK_SECOND = 8'hFD;

  // UART register indexes
  localparam logic [2:0] IDX_IER = 3'd1;
  localparam logic [2:0] IDX_LCR = 3'd3;
  localparam logic [2:0] IDX_MCR = 3'd4;

  // UART register bit values
  localparam logic [7:0] LCR_DLAB = 8'h80;
  localparam logic [7:0] LCR_8N1  = 8'h03;
  localparam logic [7:0] IER_MSI  = 8'h08;
  localparam logic [7:0] MCR_DTR  = 8'h01;
  localparam logic [7:0] MCR_RTS  = 8'h02;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

  // Number of register writes issued for the port reset
  localparam int unsigned InitWrites = 4;

  // Work classified by the front end for one item
  typedef enum logic [2:0] {
    CMD_INIT,
    CMD_RTS_LOW,
    CMD_RTS_HIGH,
    CMD_STATUS,
    CMD_KEY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] key_code;
    logic [2:0] phase;
  } cmd_t;

endpackage

FILE: design/uart_keyboard_probe_handshake.sv
// A tick's results pass through the command queue and then the output register on their way out.
// Throughput: one tick per cycle while the queue has room; the port-reset tick becomes four
// register writes in the back end.
// The command queue lets ticks keep arriving while the back end expands writes or stalls.
// Reset: phase init, tick counter zero, timeout register 100, queue and output empty.
// Top level: ties front end, command queue and back end; uses ukph_pkg.
module uart_keyboard_probe_handshake import ukph_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        rx_valid_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        reg_write_o,
  output logic [2:0]  reg_index_o,
  output logic [7:0]  reg_data_o,
  output logic        key_valid_o,
  output logic [7:0]  key_code_o,
  output logic [2:0]  link_phase_o,
  output logic        polling_stopped_o,
  output logic        last_o
);

  logic push, full, pop, head_valid;
  cmd_t push_cmd, head;

  ukph_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_valid_i   (rx_valid_i),
    .rx_byte_i    (rx_byte_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  ukph_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ukph_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reg_write_o       (reg_write_o),
    .reg_index_o       (reg_index_o),
    .reg_data_o        (reg_data_o),
    .key_valid_o       (key_valid_o),
    .key_code_o        (key_code_o),
    .link_phase_o      (link_phase_o),
    .polling_stopped_o (polling_stopped_o),
    .last_o            (last_o)
  );

endmodule

FILE: design/ukph_front.sv
// Front end: accepts poll ticks, runs the link phase machine and timeout
// counter, and pushes one classified command per item. Uses ukph_pkg.
module ukph_front import ukph_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        rx_valid_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output cmd_t        push_cmd_o
);

  logic [15:0] timeout_q;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] wait_inc;
  logic        timed_out;
  cmd_kind_e   kind;
  logic        accept;

  // Take an item whenever the queue has room
  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // Saturating tick count and timeout compare
  assign wait_inc  = (wait_q == WAIT_MAX) ? wait_q : wait_q + 16'd1;
  assign timed_out = (wait_inc >= timeout_q);

  // Advance the link phase for one tick
  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    kind    = CMD_STATUS;
    unique case (phase_q)
      PH_INIT: begin
        kind    = CMD_INIT;
        phase_d = PH_RTS_LOW;
        wait_d  = '0;
      end
      PH_RTS_LOW: begin
        kind    = CMD_RTS_LOW;
        phase_d = PH_RTS_HIGH;
      end
      PH_RTS_HIGH: begin
        kind    = CMD_RTS_HIGH;
        phase_d = PH_ACK0;
      end
      PH_ACK0: begin
        if (rx_valid_i) begin
          phase_d = (rx_byte_i == ACK_FIRST) ? PH_ACK1 : PH_RTS_LOW;
        end else begin
          wait_d  = wait_inc;
          phase_d = timed_out ? PH_GAVE_UP : PH_RTS_LOW;
        end
      end
      PH_ACK1: begin
        if (rx_valid_i) begin
          if (rx_byte_i == ACK_SECOND) begin
            phase_d = PH_CONNECTED;
            wait_d  = '0;
          end else begin
            phase_d = PH_RTS_LOW;
          end
        end else begin
          wait_d = wait_inc;
          if (timed_out) begin
            phase_d = PH_RTS_LOW;
            wait_d  = '0;
          end
        end
      end
      PH_CONNECTED: begin
        if (rx_valid_i) begin
          kind = CMD_KEY;
        end
      end
      default: begin
        phase_d = PH_GAVE_UP;
      end
    endcase
  end

  assign push_o              = accept;
  assign push_cmd_o.kind     = kind;
  assign push_cmd_o.key_code = rx_byte_i;
  assign push_cmd_o.phase    = phase_d;

  // Hold timeout register and link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      phase_q   <= PH_INIT;
      wait_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        wait_q  <= wait_d;
      end
    end
  end

  // The tick counter is cleared whenever the link comes up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_ACK1 && rx_valid_i && rx_byte_i == ACK_SECOND)
      |=> (wait_q == 16'd0 && phase_q == PH_CONNECTED))
    else $error("tick counter not cleared on connect");

endmodule

FILE: design/ukph_queue.sv
// Small command queue between front and back ends.
// Uses cmd_t from ukph_pkg.
module ukph_queue import ukph_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && !head_valid_o))
    else $error("pop from empty queue");

endmodule

FILE: design/ukph_back.sv
// Back end: expands queued commands into result items and holds them in an
// output register. Uses ukph_pkg.
module ukph_back import ukph_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       reg_write_o,
  output logic [2:0] reg_index_o,
  output logic [7:0] reg_data_o,
  output logic       key_valid_o,
  output logic [7:0] key_code_o,
  output logic [2:0] link_phase_o,
  output logic       polling_stopped_o,
  output logic       last_o
);

  localparam int unsigned BeatW = $clog2(InitWrites);

  logic [BeatW-1:0] beat_q;
  logic             out_valid_q;
  logic             load, emit, beat_last;
  logic             wr_d, kv_d, last_d;
  logic [2:0]       idx_d;
  logic [7:0]       data_d, code_d;

  // Load a new item when the output register is free or being taken
  assign load      = !out_valid_q || !out_stall_i;
  assign emit      = load && head_valid_i;
  assign beat_last = (beat_q == BeatW'(InitWrites - 1));
  assign pop_o     = emit && ((head_i.kind != CMD_INIT) || beat_last);

  // Decode the result fields for the current beat
  always_comb begin
    wr_d   = 1'b0;
    idx_d  = '0;
    data_d = '0;
    kv_d   = 1'b0;
    code_d = '0;
    last_d = 1'b1;
    unique case (head_i.kind)
      CMD_INIT: begin
        wr_d   = 1'b1;
        last_d = beat_last;
        unique case (beat_q)
          2'd0: begin
            idx_d  = IDX_LCR;
            data_d = LCR_8N1 | LCR_DLAB;
          end
          2'd1: begin
            idx_d  = IDX_LCR;
            data_d = LCR_8N1;
          end
          2'd2: begin
            idx_d  = IDX_IER;
            data_d = IER_MSI;
          end
          default: begin
            idx_d  = IDX_MCR;
            data_d = MCR_DTR;
          end
        endcase
      end
      CMD_RTS_LOW: begin
        wr_d   = 1'b1;
        idx_d  = IDX_MCR;
        data_d = MCR_DTR;
      end
      CMD_RTS_HIGH: begin
        wr_d   = 1'b1;
        idx_d  = IDX_MCR;
        data_d = MCR_DTR | MCR_RTS;
      end
      CMD_KEY: begin
        kv_d   = 1'b1;
        code_d = head_i.key_code;
      end
      default: begin
      end
    endcase
  end

  // Advance the beat counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= head_valid_i;
      end
      if (emit) begin
        beat_q <= pop_o ? '0 : beat_q + BeatW'(1);
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      reg_write_o       <= wr_d;
      reg_index_o       <= idx_d;
      reg_data_o        <= data_d;
      key_valid_o       <= kv_d;
      key_code_o        <= code_d;
      link_phase_o      <= head_i.phase;
      polling_stopped_o <= (head_i.phase == PH_GAVE_UP);
      last_o            <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A beat in progress belongs to a port reset at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != '0) |-> (head_valid_i && head_i.kind == CMD_INIT))
    else $error("beat counter running without init command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(reg_write_o && key_valid_o))
    else $error("register write and key delivery in one item");

endmodule

FILE: verif/uart_keyboard_probe_handshake_tb.sv
// Self-checking testbench for the serial keyboard probe sequencer.
// Depends on ukph_pkg and uart_keyboard_probe_handshake; predicts every result item in step.
module uart_keyboard_probe_handshake_tb;
  import ukph_pkg::*;

  typedef struct packed {
    logic       reg_write;
    logic [2:0] reg_index;
    logic [7:0] reg_data;
    logic       key_valid;
    logic [7:0] key_code;
    logic [2:0] link_phase;
    logic       polling_stopped;
    logic       last;
  } link_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        rx_valid_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        reg_write_o;
  logic [2:0]  reg_index_o;
  logic [7:0]  reg_data_o;
  logic        key_valid_o;
  logic [7:0]  key_code_o;
  logic [2:0]  link_phase_o;
  logic        polling_stopped_o;
  logic        last_o;

  // Predicted link state and the results still owed by the block
  logic [2:0]   link_phase_m = PH_INIT;
  logic [15:0]  wait_ticks_m = '0;
  logic [15:0]  timeout_m = TIMEOUT_RESET;
  link_result_t awaited_q[$];

  int unsigned mismatch_count = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  uart_keyboard_probe_handshake uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_valid_i       (rx_valid_i),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reg_write_o      (reg_write_o),
    .reg_index_o      (reg_index_o),
    .reg_data_o       (reg_data_o),
    .key_valid_o      (key_valid_o),
    .key_code_o       (key_code_o),
    .link_phase_o     (link_phase_o),
    .polling_stopped_o(polling_stopped_o),
    .last_o           (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Queue one result item, tagged with the phase reached by this tick
  function automatic void push_result(logic wr, logic [2:0] idx, logic [7:0] data,
                                      logic kv, logic [7:0] code, logic lst);
    link_result_t r;
    r.reg_write       = wr;
    r.reg_index       = idx;
    r.reg_data        = data;
    r.key_valid       = kv;
    r.key_code        = code;
    r.link_phase      = link_phase_m;
    r.polling_stopped = (link_phase_m == PH_GAVE_UP);
    r.last            = lst;
    awaited_q.push_back(r);
  endfunction

  // Advance the shared acknowledge counter, saturating; report a timeout
  function automatic logic count_wait_tick();
    if (wait_ticks_m != WAIT_MAX) wait_ticks_m = wait_ticks_m + 16'd1;
    return wait_ticks_m >= timeout_m;
  endfunction

  // Step the link sequence for one accepted tick and queue its results
  function automatic void advance_link(logic v, logic [7:0] b);
    case (link_phase_m)
      PH_INIT: begin
        link_phase_m = PH_RTS_LOW;
        wait_ticks_m = '0;
        push_result(1'b1, IDX_LCR, LCR_DLAB | LCR_8N1, 1'b0, 8'h00, 1'b0);
        push_result(1'b1, IDX_LCR, LCR_8N1, 1'b0, 8'h00, 1'b0);
        push_result(1'b1, IDX_IER, IER_MSI, 1'b0, 8'h00, 1'b0);
        push_result(1'b1, IDX_MCR, MCR_DTR, 1'b0, 8'h00, 1'b1);
      end
      PH_RTS_LOW: begin
        link_phase_m = PH_RTS_HIGH;
        push_result(1'b1, IDX_MCR, MCR_DTR, 1'b0, 8'h00, 1'b1);
      end
      PH_RTS_HIGH: begin
        link_phase_m = PH_ACK0;
        push_result(1'b1, IDX_MCR, MCR_DTR | MCR_RTS, 1'b0, 8'h00, 1'b1);
      end
      PH_ACK0: begin
        if (v) link_phase_m = (b == ACK_FIRST) ? PH_ACK1 : PH_RTS_LOW;
        else if (count_wait_tick()) link_phase_m = PH_GAVE_UP;
        else link_phase_m = PH_RTS_LOW;
        push_result(1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1);
      end
      PH_ACK1: begin
        if (v) begin
          if (b == ACK_SECOND) begin
            link_phase_m = PH_CONNECTED;
            wait_ticks_m = '0;
          end else begin
            link_phase_m = PH_RTS_LOW;
          end
        end else if (count_wait_tick()) begin
          link_phase_m = PH_RTS_LOW;
          wait_ticks_m = '0;
        end
        push_result(1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1);
      end
      PH_CONNECTED: begin
        push_result(1'b0, 3'd0, 8'h00, v, v ? b : 8'h00, 1'b1);
      end
      default: begin
        link_phase_m = PH_GAVE_UP;
        push_result(1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1);
      end
    endcase
  endfunction

  // Offer one poll tick, with random gaps; hold it until accepted
  task automatic send_tick(input logic v, input logic [7:0] b);
    while (idle_en && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_valid_i <= v;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_link(v, b);
  endtask

  // Stop offering items and wait until every owed result has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_m = value;
  endtask

  // Drive the rts low and rts high ticks with junk bytes that get dropped
  task automatic toggle_rts();
    send_tick(1'b1, 8'h00);
    send_tick(1'b0, 8'hFF);
  endtask

  // Port reset tick and both rts ticks, each carrying a byte to drop
  task automatic test_port_reset();
    send_tick(1'b1, 8'hFF);
    send_tick(1'b1, 8'h00);
    send_tick(1'b1, ACK_FIRST);
  endtask

  // Wrong acknowledges, a retry on an empty tick and waiting for the second ack
  task automatic test_ack_errors();
    send_tick(1'b1, ACK_SECOND);
    toggle_rts();
    send_tick(1'b0, 8'hA5);
    toggle_rts();
    send_tick(1'b1, ACK_FIRST);
    send_tick(1'b1, ACK_FIRST);
    toggle_rts();
    send_tick(1'b1, ACK_FIRST);
    send_tick(1'b0, 8'h5A);
  endtask

  // Smallest, zero and largest timeouts while waiting for the second ack
  task automatic test_timeout_limits();
    settle();
    write_timeout(16'd1);
    send_tick(1'b0, 8'h00);
    toggle_rts();
    send_tick(1'b1, ACK_FIRST);
    settle();
    write_timeout(16'd0);
    send_tick(1'b0, 8'hFF);
    toggle_rts();
    send_tick(1'b1, ACK_FIRST);
    settle();
    write_timeout(WAIT_MAX);
    // keep waiting under the largest timeout back to back, no gaps on either side
    idle_en = 1'b0;
    repeat (32) send_tick(1'b0, 8'($urandom_range(0, 255)));
    idle_en = 1'b1;
  endtask

  // Mostly well-formed probe sequences that never complete the link
  task automatic test_random_probing(input int unsigned count);
    logic        v;
    logic [7:0]  b;
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        settle();
        case ($urandom_range(0, 3))
          0:       write_timeout(16'd1);
          1:       write_timeout(WAIT_MAX);
          2:       write_timeout(16'($urandom_range(2, 12)));
          default: write_timeout(16'($urandom_range(1, 65535)));
        endcase
      end
      if (i == 60) hold_req = 1'b1;
      roll = $urandom_range(0, 99);
      v    = 1'($urandom_range(0, 1));
      b    = 8'($urandom_range(0, 255));
      case (link_phase_m)
        PH_ACK0: begin
          // keep clear of giving up: an empty tick only while under the timeout
          if (roll < 65) begin
            v = 1'b1;
            b = ACK_FIRST;
          end else if (roll < 80 || int'(wait_ticks_m) + 1 >= int'(timeout_m)) begin
            v = 1'b1;
          end else begin
            v = 1'b0;
          end
        end
        PH_ACK1: begin
          if (roll < 50) begin
            v = 1'b0;
          end else begin
            v = 1'b1;
            if (b == ACK_SECOND) b = ~b;
          end
        end
        default: ;
      endcase
      send_tick(v, b);
    end
  endtask

  // Finish the probe: connect and forward keys, or now and then give up for good
  task automatic test_link_end(input int unsigned count);
    bit give_up;
    give_up = ($urandom_range(0, 3) == 0);
    if (give_up) begin
      settle();
      write_timeout(16'($urandom_range(0, 6)));
      while (link_phase_m != PH_GAVE_UP) begin
        if (link_phase_m == PH_ACK0 || link_phase_m == PH_ACK1)
          send_tick(1'b0, 8'($urandom_range(0, 255)));
        else
          send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end else begin
      while (link_phase_m != PH_CONNECTED) begin
        case (link_phase_m)
          PH_ACK0: send_tick(1'b1, ACK_FIRST);
          PH_ACK1: send_tick(1'b1, ACK_SECOND);
          default: send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        endcase
      end
    end
    for (int unsigned i = 0; i < count; i++)
      send_tick($urandom_range(0, 99) < 80, 8'($urandom_range(0, 255)));
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(0, 99) < 27);
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted result item with the oldest one owed
  always @(posedge clk_i) begin : result_check
    link_result_t want;
    link_result_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = {reg_write_o, reg_index_o, reg_data_o, key_valid_o, key_code_o,
             link_phase_o, polling_stopped_o, last_o};
      if (awaited_q.size() == 0) begin
        $display("%0t: result with none awaited, expected nothing, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = awaited_q.pop_front();
        check_field("reg_write", 8'(want.reg_write), 8'(got.reg_write));
        check_field("reg_index", 8'(want.reg_index), 8'(got.reg_index));
        check_field("reg_data", want.reg_data, got.reg_data);
        check_field("key_valid", 8'(want.key_valid), 8'(got.key_valid));
        check_field("key_code", want.key_code, got.key_code);
        check_field("link_phase", 8'(want.link_phase), 8'(got.link_phase));
        check_field("polling_stopped", 8'(want.polling_stopped), 8'(got.polling_stopped));
        check_field("last", 8'(want.last), 8'(got.last));
      end
    end
  end

  initial begin
    #2000000;
    $display("uart_keyboard_probe_handshake verification failed");
    $finish;
  end

  initial begin
    in_valid_i  <= 1'b0;
    rx_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_port_reset();
    test_ack_errors();
    test_timeout_limits();
    test_random_probing(150);
    test_link_end(150);
    settle();
    if (mismatch_count == 0 && awaited_q.size() == 0) begin
      $display("uart_keyboard_probe_handshake verification clean");
    end else begin
      $display("uart_keyboard_probe_handshake verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ukph_pkg.sv
design/ukph_front.sv
design/ukph_queue.sv
design/ukph_back.sv
design/uart_keyboard_probe_handshake.sv
verif/uart_keyboard_probe_handshake_tb.sv
